// File: design/tilt_shift_blur_blend_unit_macros.svh
// ----------------------------------------------------------------------------
// tilt_shift_blur_blend_unit_macros: assertion macros
// immediate-style wrappers around concurrent properties on clk / rst
// ----------------------------------------------------------------------------
`ifndef TILT_SHIFT_BLUR_BLEND_UNIT_MACROS_SVH
`define TILT_SHIFT_BLUR_BLEND_UNIT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define TSB_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsb assertion failed");
// next-cycle implication
`define TSB_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsb assertion failed");
`else
`define TSB_ASSERT_IMPL(name, ante, cons)
`define TSB_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// File: design/tsb_pkg.sv
// ----------------------------------------------------------------------------
// tsb_pkg: shared types and constants
// item structs, register codes, tanh table built at elaboration
// ----------------------------------------------------------------------------
`default_nettype none

package tsb_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_HEIGHT   = 2048;
  localparam int TANH_ENTRIES = 128;

  localparam int ADDR_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W   = 11;
  localparam int TIDX_W  = $clog2(TANH_ENTRIES + 1);
  localparam int PADDR_W = 5;

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  localparam logic [15:0] MEAN_RECIP = 16'd58255;
  localparam int          MEAN_SHIFT = 19;

  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_FOCUS_CENTER = 3'd2;
  localparam logic [2:0] REG_FOCUS_HEIGHT = 3'd3;
  localparam logic [2:0] REG_DECAY_SCALE  = 3'd4;

  localparam logic COMMAND_PIXEL = 1'b0;
  localparam logic COMMAND_DRAIN = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } pix_item_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       end_of_line;
    logic       end_of_frame;
    logic       last_of_run;
  } res_item_t;

  typedef struct packed {
    logic [11:0] frame_width;
    logic [11:0] frame_height;
    logic [10:0] focus_center;
    logic [10:0] focus_height;
    logic [7:0]  decay_scale;
  } cfg_t;

  typedef logic [8:0] tanh_tab_t [TANH_ENTRIES + 1];

  // restoring division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh(4*i/entries) in q1.8 via fixed-point exp
  function automatic logic [8:0] tanh_entry(input int i);
    logic [63:0] z;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] e;
    z    = (64'(i) << 30) / TANH_ENTRIES;
    term = 64'd1 << 30;
    sum  = term;
    for (int k = 1; k <= 20; k++) begin
      term = udiv64((term * z) >> 30, 64'(k));
      sum  = sum + term;
    end
    e = sum >> 14;
    for (int s = 0; s < 3; s++) begin
      e = (e * e) >> 16;
    end
    if (e < 64'd65536) begin
      e = 64'd65536;
    end
    return 9'(udiv64(64'd512 * (e - 64'd65536) + e + 64'd65536, 64'd2 * (e + 64'd65536)));
  endfunction

  function automatic tanh_tab_t build_tanh();
    tanh_tab_t t;
    for (int i = 0; i <= TANH_ENTRIES; i++) begin
      t[i] = tanh_entry(i);
    end
    return t;
  endfunction

  localparam tanh_tab_t TANH_TABLE = build_tanh();

endpackage

`default_nettype wire

// File: design/tilt_shift_blur_blend_unit.sv
// ----------------------------------------------------------------------------
// tilt_shift_blur_blend_unit: tilt-shift 3x3 blur and row-weighted blend
// path: s1, lane sums, lane means, result queue; results trail by one row, one column
// one item per cycle while pix_stall is low; stall comes from the 16-entry result queue
// sync reset clears counters, column window, row weight, queue; line stores are not cleared
// ----------------------------------------------------------------------------
`default_nettype none
`include "tilt_shift_blur_blend_unit_macros.svh"

module tilt_shift_blur_blend_unit (
  input  logic                            clk,
  input  logic                            rst,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tsb_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // pixel items in
  input  logic                            pix_valid,
  output logic                            pix_stall,
  input  tsb_pkg::pix_item_t              pix_item,
  // result items out
  output logic                            res_valid,
  input  logic                            res_stall,
  output tsb_pkg::res_item_t              res_item
);
  import tsb_pkg::*;

  localparam int CW   = 14;          // compare width for column math
  localparam int DC_W = ADDR_W + 1;  // drain counter holds the width itself

  // stage 1 item: store access and emit flags
  typedef struct packed {
    logic              v;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [23:0]       px;
    logic              first_row;
    logic              c_eq1;
    logic              ea;
    logic              eb;
    logic              final_row;
  } s1_t;

  // control that follows the lanes
  typedef struct packed {
    logic ea;
    logic eb;
    logic final_row;
  } ctl_t;

  // ---------------------------------------------------------------- config
  cfg_t cfg;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= 12'd640;
      cfg.frame_height <= 12'd480;
      cfg.focus_center <= 11'd240;
      cfg.focus_height <= 11'd72;
      cfg.decay_scale  <= 8'd16;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_FRAME_WIDTH:  cfg.frame_width  <= pwdata[11:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= pwdata[11:0];
        REG_FOCUS_CENTER: cfg.focus_center <= pwdata[10:0];
        REG_FOCUS_HEIGHT: cfg.focus_height <= pwdata[10:0];
        REG_DECAY_SCALE:  cfg.decay_scale  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_FRAME_WIDTH:  prdata = 32'(cfg.frame_width);
      REG_FRAME_HEIGHT: prdata = 32'(cfg.frame_height);
      REG_FOCUS_CENTER: prdata = 32'(cfg.focus_center);
      REG_FOCUS_HEIGHT: prdata = 32'(cfg.focus_height);
      REG_DECAY_SCALE:  prdata = 32'(cfg.decay_scale);
      default:          prdata = '0;
    endcase
  end

  // clamped frame size
  logic [CW-1:0] wc;
  logic [11:0]   hc;

  assign wc = (cfg.frame_width < 12'd2) ? CW'(2) :
              (CW'(cfg.frame_width) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) :
              CW'(cfg.frame_width);
  assign hc = (cfg.frame_height < 12'd2) ? 12'd2 :
              (cfg.frame_height > 12'(MAX_HEIGHT)) ? 12'(MAX_HEIGHT) :
              cfg.frame_height;

  // ---------------------------------------------------------------- stage 0
  logic [ROW_W-1:0]  input_row;
  logic [ADDR_W-1:0] input_column;
  logic [DC_W-1:0]   drain_column;

  logic              accept;
  logic              is_drain;
  logic [ADDR_W-1:0] cd;
  logic [ADDR_W-1:0] c0;
  logic              push0;
  logic              c_last;
  logic              r_last;
  logic              upd;
  logic [ROW_W-1:0]  q0;
  logic              pix_stall_int;

  assign accept   = pix_valid && !pix_stall_int;
  assign is_drain = pix_item.command == COMMAND_DRAIN;
  assign cd       = ADDR_W'(drain_column - DC_W'(1));
  assign c0       = is_drain ? cd : input_column;
  assign push0    = is_drain ? (drain_column != '0) : (input_row != '0);
  assign c_last   = CW'(c0) >= wc - CW'(1);
  assign r_last   = 12'(input_row) >= hc - 12'd1;
  // a new row starts: refresh its weight
  assign upd      = accept && push0 && (c0 == '0);
  assign q0       = is_drain ? ROW_W'(hc - 12'd1) : input_row - ROW_W'(1);

  // raster position and pending drain
  always_ff @(posedge clk) begin
    if (rst) begin
      input_row    <= '0;
      input_column <= '0;
      drain_column <= '0;
    end else if (accept) begin
      if (is_drain) begin
        if (drain_column != '0) begin
          drain_column <= c_last ? '0 : DC_W'(cd) + DC_W'(2);
        end
      end else begin
        // a pixel drops any pending drain and continues the raster
        drain_column <= '0;
        if (c_last) begin
          input_column <= '0;
          if (r_last) begin
            input_row    <= '0;
            drain_column <= DC_W'(1);
          end else begin
            input_row <= input_row + ROW_W'(1);
          end
        end else begin
          input_column <= input_column + ADDR_W'(1);
        end
      end
    end
  end

  // ---------------------------------------------------------------- line stores
  logic [23:0] older_mem [MAX_WIDTH];
  logic [23:0] newer_mem [MAX_WIDTH];
  logic [23:0] older_rd;
  logic [23:0] newer_rd;
  s1_t         s1;

  // read at accept, write back in the following cycle (rows move up by one)
  always_ff @(posedge clk) begin
    if (accept) begin
      older_rd <= older_mem[c0];
      newer_rd <= newer_mem[c0];
    end
    if (s1.wr) begin
      older_mem[s1.addr] <= newer_rd;
      newer_mem[s1.addr] <= s1.px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else begin
      s1.v         <= accept && push0;
      s1.wr        <= accept && !is_drain;
      s1.addr      <= c0;
      s1.px        <= {pix_item.in_red, pix_item.in_green, pix_item.in_blue};
      s1.first_row <= input_row == ROW_W'(1);
      s1.c_eq1     <= c0 == ADDR_W'(1);
      s1.ea        <= accept && push0 && (c0 != '0);
      s1.eb        <= accept && push0 && c_last;
      s1.final_row <= is_drain;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // column of three pixels top to bottom; reflect at top row and at the last row
  logic [2:0][23:0] col;
  logic [23:0]      win [6];
  logic [8:0]       w_s1;

  always_comb begin
    col[0] = (s1.wr && s1.first_row) ? s1.px : older_rd;
    col[1] = newer_rd;
    col[2] = s1.wr ? s1.px : older_rd;
  end

  // entries 0..2 hold the previous column, 3..5 the one before
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (s1.v) begin
      for (int i = 0; i < 3; i++) begin
        win[i + 3] <= win[i];
        win[i]     <= col[i];
      end
    end
  end

  tsb_weight u_weight (
    .clk (clk),
    .rst (rst),
    .upd (upd),
    .q   (q0),
    .cfg (cfg),
    .w   (w_s1)
  );

  // ---------------------------------------------------------------- lanes
  // lane 0 blue, 1 green, 2 red
  logic [2:0][7:0] lane_col   [3];
  logic [2:0][7:0] lane_prev  [3];
  logic [2:0][7:0] lane_prev2 [3];
  logic [7:0]      lane_a     [3];
  logic [7:0]      lane_b     [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int j = 0; j < 3; j++) begin
        lane_col[ch][j]   = col[j][8*ch +: 8];
        lane_prev[ch][j]  = win[j][8*ch +: 8];
        lane_prev2[ch][j] = win[j + 3][8*ch +: 8];
      end
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : gen_lane
    tsb_lane u_lane (
      .clk       (clk),
      .col       (lane_col[ch]),
      .prev      (lane_prev[ch]),
      .prev2     (lane_prev2[ch]),
      .first_col (s1.c_eq1),
      .w         (w_s1),
      .res_a     (lane_a[ch]),
      .res_b     (lane_b[ch])
    );
  end

  ctl_t s2c;
  ctl_t s3c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2c <= '0;
      s3c <= '0;
    end else begin
      s2c <= '{ea: s1.ea, eb: s1.eb, final_row: s1.final_row};
      s3c <= s2c;
    end
  end

  // ---------------------------------------------------------------- merge
  // result a is the column behind, result b closes the line
  res_item_t item_a;
  res_item_t item_b;
  res_item_t slot0;
  logic [FIFO_CNT_W-1:0] count;

  always_comb begin
    item_a.out_blue     = lane_a[0];
    item_a.out_green    = lane_a[1];
    item_a.out_red      = lane_a[2];
    item_a.end_of_line  = 1'b0;
    item_a.end_of_frame = 1'b0;
    item_a.last_of_run  = !s3c.eb;
    item_b.out_blue     = lane_b[0];
    item_b.out_green    = lane_b[1];
    item_b.out_red      = lane_b[2];
    item_b.end_of_line  = 1'b1;
    item_b.end_of_frame = s3c.final_row;
    item_b.last_of_run  = 1'b1;
    slot0               = s3c.ea ? item_a : item_b;
  end

  tsb_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_a    (s3c.ea || s3c.eb),
    .item_a    (slot0),
    .push_b    (s3c.ea && s3c.eb),
    .item_b    (item_b),
    .out_valid (res_valid),
    .out_item  (res_item),
    .out_stall (res_stall),
    .count     (count)
  );

  // hold input once queued plus in-flight results could overrun the queue
  logic [FIFO_CNT_W:0] occ;

  assign occ = (FIFO_CNT_W + 1)'(count)
             + (FIFO_CNT_W + 1)'(s1.ea) + (FIFO_CNT_W + 1)'(s1.eb)
             + (FIFO_CNT_W + 1)'(s2c.ea) + (FIFO_CNT_W + 1)'(s2c.eb)
             + (FIFO_CNT_W + 1)'(s3c.ea) + (FIFO_CNT_W + 1)'(s3c.eb);
  assign pix_stall_int = occ > (FIFO_CNT_W + 1)'(FIFO_DEPTH - 2);
  assign pix_stall     = pix_stall_int;

  `TSB_ASSERT_IMPL(store_ports_apart, s1.wr && accept, s1.addr != c0)
  `TSB_ASSERT_IMPL(drain_at_line_start, drain_column != '0, input_column == '0)

endmodule

`default_nettype wire

// File: design/tsb_weight.sv
// ----------------------------------------------------------------------------
// tsb_weight: per-row blend weight
// two products registered, then tanh lookups and clamp; holds the row weight
// ----------------------------------------------------------------------------
`default_nettype none

module tsb_weight (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     upd,
  input  logic [tsb_pkg::ROW_W-1:0] q,
  input  tsb_pkg::cfg_t            cfg,
  output logic [8:0]               w
);
  import tsb_pkg::*;

  localparam int TPROD_W = 7 + $clog2(TANH_ENTRIES) + 1;

  logic signed [12:0] dq1;
  logic signed [12:0] dq2;
  logic signed [8:0]  kk;
  logic signed [21:0] d1;
  logic signed [21:0] d2;
  logic               upd_q;
  logic signed [9:0]  t1;
  logic signed [9:0]  t2;
  logic signed [10:0] diff;
  logic [9:0]         dcl;
  logic [8:0]         w_new;
  logic [8:0]         row_weight;

  function automatic logic signed [9:0] tlook(input logic signed [21:0] d);
    logic [21:0]        mag;
    logic [6:0]         m;
    logic [TPROD_W-1:0] p;
    logic [8:0]         v;
    mag = d[21] ? 22'(-d) : 22'(d);
    m   = (mag > 22'd64) ? 7'd64 : mag[6:0];
    p   = TPROD_W'(m) * TPROD_W'(TANH_ENTRIES);
    v   = TANH_TABLE[TIDX_W'(p >> 6)];
    return d[21] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  assign dq1 = $signed({2'b0, q}) - $signed({2'b0, cfg.focus_center});
  assign dq2 = dq1 - $signed({2'b0, cfg.focus_height});
  assign kk  = $signed({1'b0, cfg.decay_scale});

  always_ff @(posedge clk) begin
    d1 <= 22'(dq1 * kk);
    d2 <= 22'(dq2 * kk);
    if (rst) begin
      upd_q <= 1'b0;
    end else begin
      upd_q <= upd;
    end
  end

  assign t1    = tlook(d1);
  assign t2    = tlook(d2);
  assign diff  = 11'(t1) - 11'(t2);
  assign dcl   = diff[10] ? 10'd0 : (diff > 11'sd512) ? 10'd512 : diff[9:0];
  assign w_new = 9'((dcl + 10'd1) >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_weight <= '0;
    end else if (upd_q) begin
      row_weight <= w_new;
    end
  end

  // a new row's weight goes straight to the item that asked for it
  assign w = upd_q ? w_new : row_weight;

endmodule

`default_nettype wire

// File: design/tsb_lane.sv
// ----------------------------------------------------------------------------
// tsb_lane: one color channel
// 3x3 sums, mean by reciprocal, weighted blend for both results of an item
// ----------------------------------------------------------------------------
`default_nettype none

module tsb_lane (
  input  logic            clk,
  input  logic [2:0][7:0] col,
  input  logic [2:0][7:0] prev,
  input  logic [2:0][7:0] prev2,
  input  logic            first_col,
  input  logic [8:0]      w,
  output logic [7:0]      res_a,
  output logic [7:0]      res_b
);
  import tsb_pkg::*;

  logic [9:0]  s_col;
  logic [9:0]  s_prev;
  logic [9:0]  s_prev2;
  logic [11:0] sa;
  logic [11:0] sb;
  logic [11:0] sa2;
  logic [11:0] sb2;
  logic [7:0]  oa2;
  logic [7:0]  ob2;
  logic [8:0]  w2;
  logic [7:0]  ma;
  logic [7:0]  mb;
  logic [7:0]  ma3;
  logic [7:0]  mb3;
  logic [7:0]  oa3;
  logic [7:0]  ob3;
  logic [8:0]  w3;

  function automatic logic [7:0] mean9(input logic [11:0] s);
    logic [27:0] p;
    p = (28'(s) + 28'd4) * 28'(MEAN_RECIP);
    return 8'(p >> MEAN_SHIFT);
  endfunction

  function automatic logic [7:0] blend(input logic [8:0] wt, input logic [7:0] o,
                                       input logic [7:0] m);
    logic [17:0] v;
    v = 18'(wt) * 18'(o) + (18'd256 - 18'(wt)) * 18'(m) + 18'd128;
    return (v[17:16] != 2'b00) ? 8'd255 : v[15:8];
  endfunction

  assign s_col   = 10'(col[0]) + 10'(col[1]) + 10'(col[2]);
  assign s_prev  = 10'(prev[0]) + 10'(prev[1]) + 10'(prev[2]);
  assign s_prev2 = 10'(prev2[0]) + 10'(prev2[1]) + 10'(prev2[2]);
  // left border reflects onto the current column
  assign sa = 12'(first_col ? s_col : s_prev2) + 12'(s_prev) + 12'(s_col);
  assign sb = (12'(s_prev) << 1) + 12'(s_col);

  always_ff @(posedge clk) begin
    sa2 <= sa;
    sb2 <= sb;
    oa2 <= prev[1];
    ob2 <= col[1];
    w2  <= w;
  end

  assign ma = mean9(sa2);
  assign mb = mean9(sb2);

  always_ff @(posedge clk) begin
    ma3 <= ma;
    mb3 <= mb;
    oa3 <= oa2;
    ob3 <= ob2;
    w3  <= w2;
  end

  assign res_a = blend(w3, oa3, ma3);
  assign res_b = blend(w3, ob3, mb3);

endmodule

`default_nettype wire

// File: design/tsb_fifo.sv
// ----------------------------------------------------------------------------
// tsb_fifo: result queue
// takes up to two items a cycle, while out_stall is low hands out one
// ----------------------------------------------------------------------------
`default_nettype none
`include "tilt_shift_blur_blend_unit_macros.svh"

module tsb_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push_a,
  input  tsb_pkg::res_item_t            item_a,
  input  logic                          push_b,
  input  tsb_pkg::res_item_t            item_b,
  output logic                          out_valid,
  output tsb_pkg::res_item_t            out_item,
  input  logic                          out_stall,
  output logic [tsb_pkg::FIFO_CNT_W-1:0] count
);
  import tsb_pkg::*;

  res_item_t             mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr;
  logic [FIFO_PTR_W-1:0] rptr;
  logic                  pop;

  assign out_valid = count != '0;
  assign out_item  = mem[rptr];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem[wptr] <= item_a;
    end
    if (push_b) begin
      mem[wptr + FIFO_PTR_W'(push_a)] <= item_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + FIFO_PTR_W'(push_a) + FIFO_PTR_W'(push_b);
      rptr  <= rptr + FIFO_PTR_W'(pop);
      count <= count + FIFO_CNT_W'(push_a) + FIFO_CNT_W'(push_b) - FIFO_CNT_W'(pop);
    end
  end

  `TSB_ASSERT_IMPL(fifo_bounded, 1'b1, count <= FIFO_CNT_W'(FIFO_DEPTH))
  `TSB_ASSERT_NEXT(fifo_pop_only, pop && !push_a && !push_b, count == $past(count) - 1)

endmodule

`default_nettype wire

// File: tb/tilt_shift_blur_blend_checker.sv
// ----------------------------------------------------------------------------
// tilt_shift_blur_blend_checker: prediction and comparison
// follows register writes and accepted pixel items, computes each blended
// output pixel with its own model of the block, compares the result items
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tilt_shift_blur_blend_checker
  import tsb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pix_valid,
  input  logic                  pix_stall,
  input  pix_item_t             pix_item,
  input  logic                  res_valid,
  input  logic                  res_stall,
  input  res_item_t             res_item,
  output int                    fail_count,
  output int                    pending_results
);

  typedef logic [23:0] column_t [3];

  logic [23:0] older_line [MAX_WIDTH];
  logic [23:0] newer_line [MAX_WIDTH];
  logic [23:0] window [6];
  int unsigned row_pos, col_pos, drain_pos, weight;
  int unsigned width_reg, height_reg, center_reg, band_reg, slope_reg;
  int tanh_q [TANH_ENTRIES + 1];
  res_item_t blended_queue [$];

  function automatic int tanh_value(int i);
    logic [63:0] z, term, sum, e;
    z = (64'(i) << 30) / TANH_ENTRIES;
    term = 64'd1 << 30;
    sum = term;
    for (int k = 1; k <= 20; k++) begin
      term = ((term * z) >> 30) / 64'(k);
      sum = sum + term;
    end
    e = sum >> 14;
    for (int s = 0; s < 3; s++) e = (e * e) >> 16;
    if (e < 64'd65536) e = 64'd65536;
    return int'((64'd512 * (e - 64'd65536) + e + 64'd65536) / (64'd2 * (e + 64'd65536)));
  endfunction

  function automatic int tanh_signed(int x);
    int m;
    int v;
    m = (x < 0) ? -x : x;
    if (m > 64) m = 64;
    v = tanh_q[(m * TANH_ENTRIES) / 64];
    return (x < 0) ? -v : v;
  endfunction

  function automatic int unsigned row_weight_of(int unsigned q);
    int d1, d2, diff;
    d1 = (int'(q) - int'(center_reg)) * int'(slope_reg);
    d2 = (int'(q) - int'(center_reg) - int'(band_reg)) * int'(slope_reg);
    diff = tanh_signed(d1) - tanh_signed(d2);
    if (diff < 0) diff = 0;
    if (diff > 512) diff = 512;
    return (diff + 1) >> 1;
  endfunction

  function automatic res_item_t blend(column_t l, column_t m, column_t r, logic eol, logic eof);
    res_item_t o;
    int unsigned s, mean, v;
    logic [7:0] ch [3];
    for (int c = 0; c < 3; c++) begin
      s = 0;
      for (int j = 0; j < 3; j++)
        s += l[j][8*c +: 8] + m[j][8*c +: 8] + r[j][8*c +: 8];
      mean = (s + 4) / 9;
      v = (weight * m[1][8*c +: 8] + (256 - weight) * mean + 128) >> 8;
      ch[c] = (v > 255) ? 8'd255 : v[7:0];
    end
    o.out_blue = ch[0];
    o.out_green = ch[1];
    o.out_red = ch[2];
    o.end_of_line = eol;
    o.end_of_frame = eof;
    o.last_of_run = 1'b0;
    return o;
  endfunction

  // shift one column into the window and queue the pixels it completes
  function automatic void shift_column(column_t col, int unsigned c, int unsigned w, logic eof);
    column_t prev, prev2;
    res_item_t got [$];
    for (int j = 0; j < 3; j++) begin
      prev[j] = window[j];
      prev2[j] = window[j + 3];
      window[j + 3] = window[j];
      window[j] = col[j];
    end
    if (c >= 1) got.push_back(blend((c == 1) ? col : prev2, prev, col, 1'b0, 1'b0));
    if (c >= w - 1) got.push_back(blend(prev, col, prev, 1'b1, eof));
    if (got.size() > 0) got[got.size() - 1].last_of_run = 1'b1;
    foreach (got[i]) blended_queue.push_back(got[i]);
  endfunction

  function automatic void take_pixel(pix_item_t it);
    int unsigned w, h, c, r;
    logic [23:0] px, top, mid;
    column_t col;
    w = (width_reg < 2) ? 2 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg < 2) ? 2 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    if (it.command == COMMAND_DRAIN) begin
      if (drain_pos == 0) return;
      c = drain_pos - 1;
      if (c > MAX_WIDTH - 1) c = MAX_WIDTH - 1;
      if (c == 0) weight = row_weight_of(h - 1);
      col[0] = older_line[c];
      col[1] = newer_line[c];
      col[2] = col[0];
      shift_column(col, c, w, 1'b1);
      drain_pos = (c >= w - 1) ? 0 : c + 2;
      return;
    end
    drain_pos = 0;
    r = row_pos;
    c = (col_pos > MAX_WIDTH - 1) ? MAX_WIDTH - 1 : col_pos;
    px = {it.in_red, it.in_green, it.in_blue};
    top = older_line[c];
    mid = newer_line[c];
    older_line[c] = mid;
    newer_line[c] = px;
    if (r >= 1) begin
      if (c == 0) weight = row_weight_of(r - 1);
      col[0] = (r == 1) ? px : top;
      col[1] = mid;
      col[2] = px;
      shift_column(col, c, w, 1'b0);
    end
    if (c >= w - 1) begin
      col_pos = 0;
      if (r >= h - 1) begin
        row_pos = 0;
        drain_pos = 1;
      end else begin
        row_pos = r + 1;
      end
    end else begin
      col_pos = c + 1;
    end
  endfunction

  initial begin
    for (int i = 0; i <= TANH_ENTRIES; i++) tanh_q[i] = tanh_value(i);
    for (int i = 0; i < MAX_WIDTH; i++) begin
      older_line[i] = '0;
      newer_line[i] = '0;
    end
    fail_count = 0;
  end

  assign pending_results = blended_queue.size();

  always @(posedge clk) begin
    res_item_t want;
    if (rst) begin
      foreach (window[i]) window[i] = '0;
      row_pos = 0;
      col_pos = 0;
      drain_pos = 0;
      weight = 0;
      width_reg = 640;
      height_reg = 480;
      center_reg = 240;
      band_reg = 72;
      slope_reg = 16;
      blended_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_FRAME_WIDTH:  width_reg = pwdata[11:0];
          REG_FRAME_HEIGHT: height_reg = pwdata[11:0];
          REG_FOCUS_CENTER: center_reg = pwdata[10:0];
          REG_FOCUS_HEIGHT: band_reg = pwdata[10:0];
          REG_DECAY_SCALE:  slope_reg = pwdata[7:0];
          default: ;
        endcase
      end
      if (res_valid && !res_stall) begin
        if (blended_queue.size() == 0) begin
          $error("result item with nothing predicted");
          fail_count++;
        end else begin
          want = blended_queue.pop_front();
          if (res_item.out_blue !== want.out_blue) begin
            $error("out_blue expected %0d actual %0d", want.out_blue, res_item.out_blue);
            fail_count++;
          end
          if (res_item.out_green !== want.out_green) begin
            $error("out_green expected %0d actual %0d", want.out_green, res_item.out_green);
            fail_count++;
          end
          if (res_item.out_red !== want.out_red) begin
            $error("out_red expected %0d actual %0d", want.out_red, res_item.out_red);
            fail_count++;
          end
          if (res_item.end_of_line !== want.end_of_line) begin
            $error("end_of_line expected %0d actual %0d", want.end_of_line,
                   res_item.end_of_line);
            fail_count++;
          end
          if (res_item.end_of_frame !== want.end_of_frame) begin
            $error("end_of_frame expected %0d actual %0d", want.end_of_frame,
                   res_item.end_of_frame);
            fail_count++;
          end
          if (res_item.last_of_run !== want.last_of_run) begin
            $error("last_of_run expected %0d actual %0d", want.last_of_run,
                   res_item.last_of_run);
            fail_count++;
          end
        end
      end
      if (pix_valid && !pix_stall) take_pixel(pix_item);
    end
  end

endmodule

// File: tb/tilt_shift_blur_blend_unit_tb.sv
// ----------------------------------------------------------------------------
// tilt_shift_blur_blend_unit_tb: tilt-shift blur and blend regression
// drives whole frames plus drain ticks under many register settings with
// random gaps and back-pressure; the checker predicts and compares results
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tilt_shift_blur_blend_unit_tb;
  import tsb_pkg::*;

  logic               clk;
  logic               rst;
  logic               psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               pix_valid, pix_stall;
  pix_item_t          pix_item;
  logic               res_valid, res_stall;
  res_item_t          res_item;
  int                 fail_count, pending_results;

  // sender and receiver behavior knobs
  bit sender_gaps;
  bit receiver_gaps;
  bit hold_off_req;
  bit hold_off_done;
  int pixels_sent;

  tilt_shift_blur_blend_unit u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix_item(pix_item),
    .res_valid(res_valid), .res_stall(res_stall), .res_item(res_item)
  );

  tilt_shift_blur_blend_checker u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix_item(pix_item),
    .res_valid(res_valid), .res_stall(res_stall), .res_item(res_item),
    .fail_count(fail_count), .pending_results(pending_results)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // watchdog for a hung block
  initial begin
    #40ms;
    $display("Regression FAIL");
    $finish;
  end

  // receiver: random stall, plus one long hold-off on request once results flow
  initial begin
    res_stall = 1'b0;
    hold_off_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_done && res_valid) begin
        // hold the output side long enough for the result queue to fill
        res_stall <= 1'b1;
        repeat (400) @(negedge clk);
        hold_off_done = 1'b1;
      end
      res_stall <= receiver_gaps && ($urandom_range(99) < 27);
    end
  end

  // register write: setup cycle then access cycle
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // one item, held until accepted; optional idle cycles in front
  task automatic offer(pix_item_t it);
    @(negedge clk);
    while (sender_gaps && $urandom_range(99) < 27) begin
      pix_valid <= 1'b0;
      @(negedge clk);
    end
    pix_valid <= 1'b1;
    pix_item <= it;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    if (it.command == COMMAND_PIXEL) pixels_sent++;
  endtask

  task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    pix_item_t it;
    it.command = COMMAND_PIXEL;
    it.in_blue = b;
    it.in_green = g;
    it.in_red = r;
    offer(it);
  endtask

  task automatic send_drain();
    pix_item_t it;
    it.command = COMMAND_DRAIN;
    it.in_blue = 8'($urandom);
    it.in_green = 8'($urandom);
    it.in_red = 8'($urandom);
    offer(it);
  endtask

  // whole frame of random pixels, then some drain ticks
  task automatic send_frame(int w, int h, int drains);
    for (int i = 0; i < w * h; i++) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    for (int i = 0; i < drains; i++) send_drain();
  endtask

  // quiet the input, wait out every predicted result and the pipe latency
  task automatic settle();
    @(negedge clk);
    pix_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic configure(int w, int h, int c, int a, int k);
    settle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_FOCUS_CENTER, c);
    write_reg(REG_FOCUS_HEIGHT, a);
    write_reg(REG_DECAY_SCALE, k);
  endtask

  initial begin
    int w, h;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pix_valid = 1'b0;
    pix_item = '0;
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    hold_off_req = 1'b0;
    pixels_sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: smallest frame with extreme channel values, stray drains
    configure(2, 2, 0, 1, 16);
    send_drain();
    send_pixel(8'h00, 8'hff, 8'h00);
    send_pixel(8'hff, 8'h00, 8'hff);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_drain();
    send_drain();
    send_drain();
    // zero slope: fully blurred; width and height below range clamp up
    configure(1, 0, 2047, 2047, 0);
    send_pixel(8'h80, 8'h01, 8'hfe);
    send_pixel(8'h7f, 8'hfe, 8'h01);
    send_pixel(8'h55, 8'haa, 8'h55);
    send_pixel(8'haa, 8'h55, 8'haa);
    send_drain();
    // new frame while a drain is still pending
    send_pixel(8'h01, 8'h02, 8'h04);
    send_pixel(8'h08, 8'h10, 8'h20);
    send_pixel(8'h40, 8'h80, 8'h00);
    send_pixel(8'hff, 8'h7f, 8'h3f);
    send_drain();
    send_drain();
    // steepest transition, band starting at row 1
    configure(3, 3, 1, 1, 255);
    send_frame(3, 3, 3);

    // wider lines with the output side held off: block fills and stalls
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    configure(40, 3, 0, 0, 255);
    hold_off_req = 1'b1;
    send_frame(40, 3, 40);
    // taller frame, narrow
    configure(2, 30, 10, 4, 1);
    send_frame(2, 30, 2);

    // random settings, mostly small frames
    pixels_sent = 0;
    while (pixels_sent < 250) begin
      w = $urandom_range(2, 9);
      h = $urandom_range(2, 5);
      // one stretch with no idling at either side
      sender_gaps = !(pixels_sent >= 80 && pixels_sent < 160);
      receiver_gaps = sender_gaps;
      if ($urandom_range(7) == 0)
        configure(w, h, $urandom_range(2047), $urandom_range(2047), $urandom_range(255));
      else
        configure(w, h, $urandom_range(6), $urandom_range(5), $urandom_range(255));
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(5) == 0) send_drain();
        // usually a full drain, sometimes cut short, sometimes extra ticks
        send_frame(w, h, ($urandom_range(4) == 0) ? $urandom_range(w + 2) : w);
      end
    end

    settle();
    repeat (40) @(negedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
